FILE: hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, operation codes and pipeline item types of the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   // Fixed point format of all operands and results
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int THR_WIDTH  = 16;
   localparam int OP_WIDTH   = 4;

   // Exact product, sum of two products, and divider depth
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int DIV_STEPS  = DATA_WIDTH;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_SMUL = 4'd4,
      OP_SDIV = 4'd5,
      OP_CONJ = 4'd6,
      OP_SQR  = 4'd7,
      OP_NEG  = 4'd8
   } op_type;

   // One clipped result part
   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  sat;
   } clip_type;

   // One restoring divider lane: partial remainder, dividend bits still to
   // shift in, quotient so far (top bit means overflow) and result sign
   typedef struct packed {
      logic [PROD_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] low;
      logic [DATA_WIDTH-1:0] quo;
      logic                  neg;
   } div_lane_type;

   // Result control that rides along the divider
   typedef struct packed {
      logic                  is_div;
      logic                  dz;
      logic                  sat;
      logic [DATA_WIDTH-1:0] y_re;
      logic [DATA_WIDTH-1:0] y_im;
   } ctl_type;

   typedef struct packed {
      div_lane_type          re;
      div_lane_type          im;
      logic [PROD_WIDTH-1:0] den;
      ctl_type               ctl;
   } div_item_type;

endpackage

FILE: hdl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Q16.16 complex add, subtract, multiply, divide, scalar multiply and divide,
// conjugate, square and negate, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// One operation enters on every clock cycle; busy stays low. Every result
// appears on rsp_valid in order, and all operations take the same path:
// three stages for products, their sums and operand setup, 32
// stages of a restoring divider that produces one quotient bit
// per stage for both result parts, and one output register. Results cannot
// be held off; each is shown for one cycle. Write zero_threshold only while
// no operation is in flight.
module complex_arithmetic_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [cau_pkg::OP_WIDTH-1:0]         req_op,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_a_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_a_im,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_b_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_b_im,
   output logic                                 rsp_valid,
   output logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_y_re,
   output logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_y_im,
   output logic                                 rsp_div_by_zero,
   output logic                                 rsp_saturated,
   input  logic                                 csr_wr_en,
   input  logic [cau_pkg::THR_WIDTH-1:0]        csr_wr_data
);
   import cau_pkg::*;

   localparam int LATENCY = DIV_STEPS + 4;

   // Turn a divider lane into a clipped signed result
   function automatic clip_type finish_lane(input div_lane_type l);
      clip_type r;
      if (l.quo[DATA_WIDTH-1]) begin
         r.sat   = 1'b1;
         r.value = l.neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                         : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
         r.sat   = 1'b0;
         r.value = l.neg ? (DATA_WIDTH'(0) - l.quo) : l.quo;
      end
      return r;
   endfunction

   // Threshold register
   logic [THR_WIDTH-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Fully pipelined: never stall the request side
   assign busy = 1'b0;

   // Front stages
   logic                 chain_vld [DIV_STEPS+1];
   div_item_type         chain_item [DIV_STEPS+1];

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (start & ~busy),
      .in_op    (req_op),
      .in_a_re  (req_a_re),
      .in_a_im  (req_a_im),
      .in_b_re  (req_b_re),
      .in_b_im  (req_b_im),
      .zero_thr (thr_ff),
      .out_vld  (chain_vld[0]),
      .out_item (chain_item[0])
   );

   // Divider chain, one quotient bit per stage
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      cau_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (chain_vld[s]),
         .in_item  (chain_item[s]),
         .out_vld  (chain_vld[s+1]),
         .out_item (chain_item[s+1])
      );
   end

   // Output register
   clip_type              fin_re, fin_im;
   ctl_type               last_ctl;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] y_re_ff, y_im_ff, y_re_in, y_im_in;
   logic                  dz_ff, sat_ff, sat_in;

   always_comb begin
      last_ctl = chain_item[DIV_STEPS].ctl;
      fin_re   = finish_lane(chain_item[DIV_STEPS].re);
      fin_im   = finish_lane(chain_item[DIV_STEPS].im);
      if (last_ctl.is_div) begin
         y_re_in = fin_re.value;
         y_im_in = fin_im.value;
         sat_in  = fin_re.sat | fin_im.sat;
      end else begin
         y_re_in = last_ctl.y_re;
         y_im_in = last_ctl.y_im;
         sat_in  = last_ctl.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_vld[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      y_re_ff <= y_re_in;
      y_im_ff <= y_im_in;
      dz_ff   <= last_ctl.dz;
      sat_ff  <= sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_y_re        = y_re_ff;
   assign rsp_y_im        = y_im_ff;
   assign rsp_div_by_zero = dz_ff;
   assign rsp_saturated   = sat_ff;

   // Every accepted start yields a result on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after fixed latency");

   // A zero divisor gives a zero, unsaturated result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |->
         (rsp_y_re == '0 && rsp_y_im == '0 && !rsp_saturated))
      else $error("divide-by-zero result not cleared");

endmodule

FILE: hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Three pipeline stages: operand products, product sums, then rescaling of
// products and setup of the divider lanes.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_vld,
   input  logic [cau_pkg::OP_WIDTH-1:0]         in_op,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
   input  logic [cau_pkg::THR_WIDTH-1:0]        zero_thr,
   output logic                                 out_vld,
   output cau_pkg::div_item_type                out_item
);
   import cau_pkg::*;

   // Clip a wide signed value to the data width
   function automatic clip_type clip_word(input logic signed [SUM_WIDTH-1:0] v);
      clip_type                         r;
      logic [SUM_WIDTH-DATA_WIDTH:0]    top;
      top = v[SUM_WIDTH-1:DATA_WIDTH-1];
      if (&top || ~|top) begin
         r.value = v[DATA_WIDTH-1:0];
         r.sat   = 1'b0;
      end else begin
         r.sat   = 1'b1;
         r.value = v[SUM_WIDTH-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                  : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SUM_WIDTH-1:0] ext_word(
      input logic signed [DATA_WIDTH-1:0] w);
      return {{(SUM_WIDTH-DATA_WIDTH){w[DATA_WIDTH-1]}}, w};
   endfunction

   function automatic logic signed [SUM_WIDTH-1:0] ext_prod(
      input logic signed [PROD_WIDTH-1:0] p);
      return {{(SUM_WIDTH-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
   endfunction

   function automatic logic [DATA_WIDTH-1:0] abs_word(
      input logic signed [DATA_WIDTH-1:0] w);
      return w[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - w) : w;
   endfunction

   // ---------------- stage A: products ----------------
   logic signed [DATA_WIDTH-1:0] sel_y0, sel_y1;
   logic signed [PROD_WIDTH-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;

   logic                         a_vld_ff;
   logic [OP_WIDTH-1:0]          a_op_ff;
   logic signed [DATA_WIDTH-1:0] a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;
   logic signed [PROD_WIDTH-1:0] a_p0_ff, a_p1_ff, a_p2_ff, a_p3_ff, a_p4_ff, a_p5_ff;

   // Square reuses the multipliers with A in place of B
   always_comb begin
      sel_y0 = (in_op == OP_SQR) ? in_a_re : in_b_re;
      sel_y1 = (in_op == OP_SQR) ? in_a_im : in_b_im;
      p0_in  = in_a_re * sel_y0;
      p1_in  = in_a_im * sel_y1;
      p2_in  = in_a_re * sel_y1;
      p3_in  = in_a_im * in_b_re;
      p4_in  = in_b_re * in_b_re;
      p5_in  = in_b_im * in_b_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff <= in_op;
      a_ar_ff <= in_a_re;
      a_ai_ff <= in_a_im;
      a_br_ff <= in_b_re;
      a_bi_ff <= in_b_im;
      a_p0_ff <= p0_in;
      a_p1_ff <= p1_in;
      a_p2_ff <= p2_in;
      a_p3_ff <= p3_in;
      a_p4_ff <= p4_in;
      a_p5_ff <= p5_in;
   end

   // ---------------- stage B: sums ----------------
   logic signed [SUM_WIDTH-1:0]  sr_in, si_in;
   logic [PROD_WIDTH-1:0]        den_in;
   clip_type                     sre_in, sim_in;

   logic                         b_vld_ff;
   logic [OP_WIDTH-1:0]          b_op_ff;
   logic signed [SUM_WIDTH-1:0]  b_sr_ff, b_si_ff;
   logic [PROD_WIDTH-1:0]        b_den_ff;
   clip_type                     b_sre_ff, b_sim_ff;
   logic signed [DATA_WIDTH-1:0] b_ar_ff, b_ai_ff, b_br_ff;

   // Combine products per operation
   always_comb begin
      case (a_op_ff)
         OP_MUL: begin
            sr_in = ext_prod(a_p0_ff) - ext_prod(a_p1_ff);
            si_in = ext_prod(a_p2_ff) + ext_prod(a_p3_ff);
         end
         OP_SQR: begin
            sr_in = ext_prod(a_p0_ff) - ext_prod(a_p1_ff);
            si_in = ext_prod(a_p2_ff) + ext_prod(a_p2_ff);
         end
         OP_DIV: begin
            sr_in = ext_prod(a_p0_ff) + ext_prod(a_p1_ff);
            si_in = ext_prod(a_p3_ff) - ext_prod(a_p2_ff);
         end
         default: begin
            sr_in = ext_prod(a_p0_ff);
            si_in = ext_prod(a_p3_ff);
         end
      endcase
      den_in = $unsigned(a_p4_ff) + $unsigned(a_p5_ff);
   end

   // Add, subtract, conjugate and negate finish here
   always_comb begin
      sre_in = '0;
      sim_in = '0;
      case (a_op_ff)
         OP_ADD: begin
            sre_in = clip_word(ext_word(a_ar_ff) + ext_word(a_br_ff));
            sim_in = clip_word(ext_word(a_ai_ff) + ext_word(a_bi_ff));
         end
         OP_SUB: begin
            sre_in = clip_word(ext_word(a_ar_ff) - ext_word(a_br_ff));
            sim_in = clip_word(ext_word(a_ai_ff) - ext_word(a_bi_ff));
         end
         OP_CONJ: begin
            sre_in.value = a_ar_ff;
            sim_in = clip_word(SUM_WIDTH'(0) - ext_word(a_ai_ff));
         end
         OP_NEG: begin
            sre_in = clip_word(SUM_WIDTH'(0) - ext_word(a_ar_ff));
            sim_in = clip_word(SUM_WIDTH'(0) - ext_word(a_ai_ff));
         end
         default: begin
            sre_in = '0;
            sim_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_op_ff  <= a_op_ff;
      b_sr_ff  <= sr_in;
      b_si_ff  <= si_in;
      b_den_ff <= den_in;
      b_sre_ff <= sre_in;
      b_sim_ff <= sim_in;
      b_ar_ff  <= a_ar_ff;
      b_ai_ff  <= a_ai_ff;
      b_br_ff  <= a_br_ff;
   end

   // ---------------- stage C: rescale and divider setup ----------------
   clip_type                     fr, fi;
   logic signed [SUM_WIDTH-1:0]  sr_abs, si_abs;
   logic [PROD_WIDTH-1:0]        num_re, num_im, den_sel;
   logic                         neg_re, neg_im, is_zero;
   div_item_type                 item_in;

   logic                         c_vld_ff;
   div_item_type                 c_item_ff;

   always_comb begin
      // Floor rescale of products, then clip
      fr = clip_word(b_sr_ff >>> FRAC_BITS);
      fi = clip_word(b_si_ff >>> FRAC_BITS);
      sr_abs = b_sr_ff[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - b_sr_ff) : b_sr_ff;
      si_abs = b_si_ff[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - b_si_ff) : b_si_ff;

      // Divider operands as sign and magnitude
      num_re  = '0;
      num_im  = '0;
      neg_re  = 1'b0;
      neg_im  = 1'b0;
      den_sel = '0;
      is_zero = 1'b0;
      case (b_op_ff)
         OP_DIV: begin
            num_re  = sr_abs[PROD_WIDTH-1:0];
            num_im  = si_abs[PROD_WIDTH-1:0];
            neg_re  = b_sr_ff[SUM_WIDTH-1];
            neg_im  = b_si_ff[SUM_WIDTH-1];
            den_sel = b_den_ff;
            is_zero = (b_den_ff >> FRAC_BITS) <= PROD_WIDTH'(zero_thr);
         end
         OP_SDIV: begin
            num_re  = PROD_WIDTH'(abs_word(b_ar_ff));
            num_im  = PROD_WIDTH'(abs_word(b_ai_ff));
            neg_re  = b_ar_ff[DATA_WIDTH-1] ^ b_br_ff[DATA_WIDTH-1];
            neg_im  = b_ai_ff[DATA_WIDTH-1] ^ b_br_ff[DATA_WIDTH-1];
            den_sel = PROD_WIDTH'(abs_word(b_br_ff));
            is_zero = abs_word(b_br_ff) <= DATA_WIDTH'(zero_thr);
         end
         default: begin
            num_re  = '0;
         end
      endcase

      // Lanes start with the dividend shifted so the quotient has DATA_WIDTH bits
      item_in.re.rem = num_re >> (DATA_WIDTH - FRAC_BITS);
      item_in.re.low = num_re[DATA_WIDTH-1:0] << FRAC_BITS;
      item_in.re.quo = '0;
      item_in.re.neg = neg_re;
      item_in.im.rem = num_im >> (DATA_WIDTH - FRAC_BITS);
      item_in.im.low = num_im[DATA_WIDTH-1:0] << FRAC_BITS;
      item_in.im.quo = '0;
      item_in.im.neg = neg_im;
      item_in.den    = den_sel;

      // Result for everything that bypasses the divider
      item_in.ctl.is_div = 1'b0;
      item_in.ctl.dz     = 1'b0;
      item_in.ctl.y_re   = b_sre_ff.value;
      item_in.ctl.y_im   = b_sim_ff.value;
      item_in.ctl.sat    = b_sre_ff.sat | b_sim_ff.sat;
      case (b_op_ff)
         OP_MUL, OP_SQR, OP_SMUL: begin
            item_in.ctl.y_re = fr.value;
            item_in.ctl.y_im = fi.value;
            item_in.ctl.sat  = fr.sat | fi.sat;
         end
         OP_DIV, OP_SDIV: begin
            item_in.ctl.is_div = ~is_zero;
            item_in.ctl.dz     = is_zero;
            item_in.ctl.y_re   = '0;
            item_in.ctl.y_im   = '0;
            item_in.ctl.sat    = 1'b0;
         end
         default: begin
            item_in.ctl.is_div = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_item_ff <= item_in;
   end

   assign out_vld  = c_vld_ff;
   assign out_item = c_item_ff;

endmodule

FILE: hdl/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring divide step: one quotient bit for each of the
// real and imaginary lanes.
// ----------------------------------------------------------------------------
module cau_div_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  cau_pkg::div_item_type in_item,
   output logic                  out_vld,
   output cau_pkg::div_item_type out_item
);
   import cau_pkg::*;

   // Shift in the next dividend bit, subtract the divisor where it fits
   function automatic div_lane_type div_bit(input div_lane_type l,
                                            input logic [PROD_WIDTH-1:0] den);
      div_lane_type          r;
      logic [PROD_WIDTH:0]   trial;
      logic [PROD_WIDTH+1:0] diff;
      logic                  fits;
      trial = {l.rem, l.low[DATA_WIDTH-1]};
      diff  = {1'b0, trial} - {2'b00, den};
      fits  = ~diff[PROD_WIDTH+1];
      r.rem = fits ? diff[PROD_WIDTH-1:0] : trial[PROD_WIDTH-1:0];
      r.low = l.low << 1;
      r.quo = {l.quo[DATA_WIDTH-2:0], fits};
      r.neg = l.neg;
      return r;
   endfunction

   div_item_type item_in;
   logic         vld_ff;
   div_item_type item_ff;

   always_comb begin
      item_in    = in_item;
      item_in.re = div_bit(in_item.re, in_item.den);
      item_in.im = div_bit(in_item.im, in_item.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_vld  = vld_ff;
   assign out_item = item_ff;

endmodule
